/* rtl/dlml_pkg.sv */
// Package for the longest-match DFA lexer: opcodes, result kinds, sizes, result record.
// No dependencies; used by dfa_longest_match_lexer.
`default_nettype none
package dlml_pkg;

    localparam int MaxStates  = 256;
    localparam int MaxClasses = 64;
    localparam int MaxLexeme  = 32;
    localparam int RowWidth   = MaxClasses + 1;
    localparam int TransDepth = MaxStates * RowWidth;
    localparam int TransAw    = $clog2(TransDepth);
    localparam int LaAw       = $clog2(MaxLexeme);

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_EOI   = 2'd1;
    localparam logic [1:0] OP_CMAP  = 2'd2;
    localparam logic [1:0] OP_TRANS = 2'd3;

    localparam logic [1:0] KIND_TOKEN    = 2'd0;
    localparam logic [1:0] KIND_NOMATCH  = 2'd1;
    localparam logic [1:0] KIND_EOI      = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef struct packed {
        logic [31:0] last_column;
        logic [31:0] last_line;
        logic [31:0] first_column;
        logic [31:0] first_line;
        logic [5:0]  token_length;
        logic [7:0]  token_type;
        logic [1:0]  result_kind;
    } res_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        sat_inc = (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

endpackage
`default_nettype wire

/* rtl/dlml_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module dlml_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/dfa_longest_match_lexer.sv */
// Longest-match DFA lexer: class map and transition table in RAMs, lookahead ring, sequencer.
// Depends on dlml_pkg and dlml_ram.
//
//  channel  | direction | payload
//  s_*      | in        | tuser opcode, tdata byte/row/col/value
//  cfg_*    | in        | cfg_data num_classes
//  m_*      | out       | tuser kind, tdata token fields, tlast last of run
//
// A table write completes on acceptance and leaves the sequencer idle. A data byte takes
// the accept, then per scanned byte the steps loop check, line/column update, class RAM
// read, transition RAM read and accept RAM read (a dead byte skips the reads it no longer
// needs), an accept RAM read for the start state on the first byte of a lexeme, a finish
// step per emitted result and a wrap-up; retracted bytes are rescanned the same way.
// Results wait in a one-deep hold so the last one can be tagged; a stalled m_tready stalls
// the sequencer. Reset clears control state only; the tables are undefined until written.
`default_nettype none
module dfa_longest_match_lexer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,   // opcode
    input  wire logic [31:0]  s_tdata,   // data_byte, table_row, table_col, table_value
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [6:0]   cfg_data,  // num_classes
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [1:0]        m_tuser,   // result_kind
    output logic              m_tlast,   // last_of_run
    output logic [143:0]      m_tdata    // token_type, token_length, first_line,
                                         // first_column, last_line, last_column, pad
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_ACC0, S_STEP, S_CLS, S_NXT, S_ACC, S_FIN, S_EOI, S_END
    } state_t;

    state_t state_reg;

    logic [7:0]  in_byte, in_row;
    logic [6:0]  in_col;
    logic [8:0]  in_val;
    assign in_byte = s_tdata[7:0];
    assign in_row  = s_tdata[15:8];
    assign in_col  = s_tdata[22:16];
    assign in_val  = s_tdata[31:23];

    logic [6:0]  num_classes_reg;
    logic [5:0]  fill_reg, pos_reg, acc_len_reg;
    logic [dlml_pkg::LaAw-1:0] head_reg;
    logic [7:0]  dfa_reg;
    logic [8:0]  acc_type_reg;
    logic [31:0] line_reg, col_reg;
    logic [31:0] start_line_reg, start_col_reg, acc_line_reg, acc_col_reg;
    logic        halted_reg, eoi_mode_reg;
    logic        pend_valid_reg;
    dlml_pkg::res_t pend_reg, out_reg;
    logic        out_valid_reg, out_last_reg;
    logic [7:0]  la_mem [dlml_pkg::MaxLexeme];

    logic accept_in;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept_in = s_tvalid && s_tready;

    // class map RAM
    logic        cm_we;
    logic [7:0]  cm_raddr;
    logic [5:0]  cm_rdata;
    logic [7:0]  cur_byte;
    assign cur_byte = la_mem[head_reg + pos_reg[dlml_pkg::LaAw-1:0]];
    assign cm_we    = accept_in && (s_tuser == dlml_pkg::OP_CMAP);
    assign cm_raddr = cur_byte;

    dlml_ram #(.Width(6), .Depth(256)) u_cmap (
        .aclk(aclk), .we(cm_we), .waddr(in_byte), .wdata(in_val[5:0]),
        .raddr(cm_raddr), .rdata(cm_rdata)
    );

    // transition RAM, row-major with MaxClasses+1 columns
    logic                        tt_we;
    logic [dlml_pkg::TransAw-1:0] tt_waddr, tt_raddr;
    logic [8:0]                  tt_rdata;
    logic [7:0]                  rd_row;
    logic [6:0]                  rd_col;

    function automatic logic [dlml_pkg::TransAw-1:0] taddr(input logic [7:0] r,
                                                          input logic [6:0] c);
        taddr = dlml_pkg::TransAw'(r) * dlml_pkg::TransAw'(dlml_pkg::RowWidth)
              + dlml_pkg::TransAw'(c);
    endfunction

    function automatic dlml_pkg::res_t plain_of(input logic [1:0] kind);
        plain_of = '0;
        plain_of.result_kind = kind;
    endfunction

    assign tt_we    = accept_in && (s_tuser == dlml_pkg::OP_TRANS)
                   && (in_col <= 7'(dlml_pkg::MaxClasses));
    assign tt_waddr = taddr(in_row, in_col);

    always_comb begin
        rd_row = dfa_reg;
        rd_col = num_classes_reg;
        if (state_reg == S_CLS) begin
            rd_col = {1'b0, cm_rdata};
        end else if (state_reg == S_NXT) begin
            rd_row = tt_rdata[7:0];
        end
    end
    assign tt_raddr = taddr(rd_row, rd_col);

    dlml_ram #(.Width(9), .Depth(dlml_pkg::TransDepth)) u_trans (
        .aclk(aclk), .we(tt_we), .waddr(tt_waddr), .wdata(in_val),
        .raddr(tt_raddr), .rdata(tt_rdata)
    );

    logic out_free, emit_ok, nomatch, load_out;
    assign out_free = !out_valid_reg || m_tready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign nomatch  = acc_type_reg[8] || (acc_len_reg == 6'd0) || (acc_len_reg > fill_reg);
    // held result moves to the output register
    assign load_out = pend_valid_reg && (
           ((state_reg == S_FIN) && emit_ok)
        || ((state_reg == S_EOI) && !halted_reg && (fill_reg == 6'd0) && emit_ok)
        || ((state_reg == S_END) && out_free));

    dlml_pkg::res_t tok_res;
    always_comb begin
        tok_res = '0;
        tok_res.result_kind  = dlml_pkg::KIND_TOKEN;
        tok_res.token_type   = acc_type_reg[7:0];
        tok_res.token_length = acc_len_reg;
        tok_res.first_line   = start_line_reg;
        tok_res.first_column = start_col_reg;
        tok_res.last_line    = acc_line_reg;
        tok_res.last_column  = acc_col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            num_classes_reg <= 7'd1;
            fill_reg        <= '0;
            pos_reg         <= '0;
            head_reg        <= '0;
            dfa_reg         <= '0;
            acc_type_reg    <= '1;
            acc_len_reg     <= '0;
            line_reg        <= 32'd1;
            col_reg         <= '0;
            start_line_reg  <= '0;
            start_col_reg   <= '0;
            acc_line_reg    <= '0;
            acc_col_reg     <= '0;
            halted_reg      <= 1'b0;
            eoi_mode_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                num_classes_reg <= (cfg_data > 7'(dlml_pkg::MaxClasses))
                                 ? 7'(dlml_pkg::MaxClasses) : cfg_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept_in && !halted_reg) begin
                        if (s_tuser == dlml_pkg::OP_DATA) begin
                            eoi_mode_reg <= 1'b0;
                            if (fill_reg >= 6'(dlml_pkg::MaxLexeme)) begin
                                pend_reg       <= plain_of(dlml_pkg::KIND_OVERFLOW);
                                pend_valid_reg <= 1'b1;
                                halted_reg     <= 1'b1;
                                state_reg      <= S_END;
                            end else begin
                                la_mem[head_reg + fill_reg[dlml_pkg::LaAw-1:0]] <= in_byte;
                                fill_reg  <= fill_reg + 6'd1;
                                state_reg <= S_LOOP;
                            end
                        end else if (s_tuser == dlml_pkg::OP_EOI) begin
                            eoi_mode_reg <= 1'b1;
                            state_reg    <= S_LOOP;
                        end
                    end
                end
                S_LOOP: begin
                    if (halted_reg || pos_reg >= fill_reg) begin
                        state_reg <= eoi_mode_reg ? S_EOI : S_END;
                    end else begin
                        state_reg <= (pos_reg == 6'd0) ? S_ACC0 : S_STEP;
                    end
                end
                S_ACC0: begin
                    if (!tt_rdata[8]) begin
                        acc_type_reg <= tt_rdata;
                        acc_len_reg  <= pos_reg;
                        acc_line_reg <= line_reg;
                        acc_col_reg  <= col_reg;
                    end
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    // line/column after this byte; lexeme start taken on its first byte
                    if (cur_byte == dlml_pkg::NEWLINE) begin
                        line_reg <= dlml_pkg::sat_inc(line_reg);
                        col_reg  <= '0;
                        if (pos_reg == 6'd0) begin
                            start_line_reg <= dlml_pkg::sat_inc(line_reg);
                            start_col_reg  <= '0;
                        end
                    end else begin
                        col_reg <= dlml_pkg::sat_inc(col_reg);
                        if (pos_reg == 6'd0) begin
                            start_line_reg <= line_reg;
                            start_col_reg  <= dlml_pkg::sat_inc(col_reg);
                        end
                    end
                    state_reg <= S_CLS;
                end
                S_CLS: begin
                    if ({1'b0, cm_rdata} >= num_classes_reg) begin
                        pos_reg   <= pos_reg + 6'd1;
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_NXT;
                    end
                end
                S_NXT: begin
                    pos_reg <= pos_reg + 6'd1;
                    if (tt_rdata[8]) begin
                        state_reg <= S_FIN;
                    end else begin
                        dfa_reg   <= tt_rdata[7:0];
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (!tt_rdata[8]) begin
                        acc_type_reg <= tt_rdata;
                        acc_len_reg  <= pos_reg;
                        acc_line_reg <= line_reg;
                        acc_col_reg  <= col_reg;
                    end
                    state_reg <= S_LOOP;
                end
                S_FIN: begin
                    if (emit_ok) begin
                        if (pend_valid_reg) begin
                            out_reg      <= pend_reg;
                            out_last_reg <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        if (nomatch) begin
                            pend_reg   <= plain_of(dlml_pkg::KIND_NOMATCH);
                            halted_reg <= 1'b1;
                        end else begin
                            pend_reg     <= tok_res;
                            line_reg     <= acc_line_reg;
                            col_reg      <= acc_col_reg;
                            head_reg     <= head_reg + acc_len_reg[dlml_pkg::LaAw-1:0];
                            fill_reg     <= fill_reg - acc_len_reg;
                            dfa_reg      <= '0;
                            pos_reg      <= '0;
                            acc_type_reg <= '1;
                            acc_len_reg  <= '0;
                        end
                        state_reg <= S_LOOP;
                    end
                end
                S_EOI: begin
                    if (halted_reg) begin
                        state_reg <= S_END;
                    end else if (fill_reg != 6'd0) begin
                        state_reg <= S_FIN;
                    end else if (emit_ok) begin
                        if (pend_valid_reg) begin
                            out_reg      <= pend_reg;
                            out_last_reg <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_reg       <= plain_of(dlml_pkg::KIND_EOI);
                        dfa_reg        <= '0;
                        pos_reg        <= '0;
                        acc_type_reg   <= '1;
                        acc_len_reg    <= '0;
                        state_reg      <= S_END;
                    end
                end
                S_END: begin
                    if (!pend_valid_reg) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reg.result_kind;
    assign m_tdata  = {2'b00, out_reg.last_column, out_reg.last_line, out_reg.first_column,
                       out_reg.first_line, out_reg.token_length, out_reg.token_type};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 6'(dlml_pkg::MaxLexeme))
        else $error("lookahead fill beyond capacity");
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= fill_reg)
        else $error("scan position beyond fill");
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left behind at idle");
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for dfa_longest_match_lexer: queued request driver, result monitor
// and an in-bench longest-match predictor. Depends on dlml_pkg and the lexer RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit   = 5000;
    localparam int DrainWait   = 200;
    localparam int HoldLen     = 400;
    localparam int Rows        = 6;   // DFA states used by the generated tables
    localparam int UsedClasses = 4;   // classes the class map hands out
    localparam int AlphaSize   = 6;
    localparam logic [7:0] Alphabet [AlphaSize] =
        '{8'h00, 8'hFF, dlml_pkg::NEWLINE, 8'h41, 8'h42, 8'h20};

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        chr;
        logic [7:0]        row;
        logic [6:0]        col;
        logic signed [8:0] val;
    } lex_req_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [31:0]  s_tdata = '0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [6:0]   cfg_data = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic [143:0] m_tdata;

    always #1 aclk = ~aclk;

    dfa_longest_match_lexer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tdata(m_tdata)
    );

    // ---------------- lexer predictor ----------------
    logic [5:0]        cmap_p [256];
    logic signed [8:0] trans_p [dlml_pkg::MaxStates][dlml_pkg::RowWidth];
    logic [7:0]        la_p [dlml_pkg::MaxLexeme];
    int                fill_p, pos_p, state_p, acc_type_p, acc_len_p, classes_p;
    logic [31:0]       line_p, col_p, tok_line_p, tok_col_p, acc_line_p, acc_col_p;
    bit                halt_p;

    dlml_pkg::res_t tok_q [$];   // expected results, oldest first
    bit             tok_last_q [$];
    dlml_pkg::res_t step_q [$];

    function void emit_tok(logic [1:0] kind, logic [7:0] ty, logic [5:0] len,
                           logic [31:0] fl, logic [31:0] fc, logic [31:0] ll,
                           logic [31:0] lc);
        dlml_pkg::res_t r;
        r.result_kind = kind;
        r.token_type = ty;
        r.token_length = len;
        r.first_line = fl;
        r.first_column = fc;
        r.last_line = ll;
        r.last_column = lc;
        step_q.push_back(r);
    endfunction

    function void restart_scan();
        state_p = 0;
        pos_p = 0;
        acc_type_p = -1;
        acc_len_p = 0;
    endfunction

    function void note_accept();
        int t;
        t = int'(trans_p[state_p][classes_p]);
        if (t >= 0) begin
            acc_type_p = t;
            acc_len_p = pos_p;
            acc_line_p = line_p;
            acc_col_p = col_p;
        end
    endfunction

    function void close_token();
        int len;
        len = acc_len_p;
        if (acc_type_p < 0 || len == 0 || len > fill_p) begin
            emit_tok(dlml_pkg::KIND_NOMATCH, '0, '0, '0, '0, '0, '0);
            halt_p = 1'b1;
            return;
        end
        emit_tok(dlml_pkg::KIND_TOKEN, acc_type_p[7:0], len[5:0], tok_line_p, tok_col_p,
                 acc_line_p, acc_col_p);
        line_p = acc_line_p;
        col_p = acc_col_p;
        for (int i = 0; i < fill_p - len; i++) la_p[i] = la_p[i + len];
        fill_p -= len;
        restart_scan();
    endfunction

    function automatic logic [31:0] sat_step(logic [31:0] x);
        return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    function void rescan();
        logic [7:0] b;
        int cls, nx;
        bit dead;
        while (!halt_p && pos_p < fill_p) begin
            b = la_p[pos_p];
            nx = -1;
            if (pos_p == 0) note_accept();
            if (b == dlml_pkg::NEWLINE) begin
                line_p = sat_step(line_p);
                col_p = '0;
            end else begin
                col_p = sat_step(col_p);
            end
            if (pos_p == 0) begin
                tok_line_p = line_p;
                tok_col_p = col_p;
            end
            cls = cmap_p[b];
            dead = cls >= classes_p;
            if (!dead) begin
                nx = int'(trans_p[state_p][cls]);
                dead = nx < 0 || nx >= dlml_pkg::MaxStates;
            end
            pos_p++;
            if (dead) close_token();
            else begin
                state_p = nx;
                note_accept();
            end
        end
    endfunction

    function void predict(lex_req_t q);
        step_q.delete();
        case (q.op)
            dlml_pkg::OP_CMAP: cmap_p[q.chr] = q.val[5:0];
            dlml_pkg::OP_TRANS: begin
                if (q.col <= dlml_pkg::MaxClasses) trans_p[q.row][q.col] = q.val;
            end
            dlml_pkg::OP_DATA: begin
                if (!halt_p) begin
                    if (fill_p >= dlml_pkg::MaxLexeme) begin
                        emit_tok(dlml_pkg::KIND_OVERFLOW, '0, '0, '0, '0, '0, '0);
                        halt_p = 1'b1;
                    end else begin
                        la_p[fill_p] = q.chr;
                        fill_p++;
                        rescan();
                    end
                end
            end
            dlml_pkg::OP_EOI: begin
                if (!halt_p) begin
                    while (!halt_p && fill_p > 0) begin
                        close_token();
                        rescan();
                    end
                    if (!halt_p) begin
                        emit_tok(dlml_pkg::KIND_EOI, '0, '0, '0, '0, '0, '0);
                        restart_scan();
                    end
                end
            end
            default: ;
        endcase
        foreach (step_q[i]) begin
            tok_q.push_back(step_q[i]);
            tok_last_q.push_back(i == step_q.size() - 1);
        end
    endfunction

    // ---------------- request driver ----------------
    lex_req_t pend_q [$];
    lex_req_t cur_req;
    int       n_pushed = 0, n_taken = 0;
    bit       quiet = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict(cur_req);
                n_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pend_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
                    cur_req = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_req.op;
                    s_tdata <= {cur_req.val, cur_req.col, cur_req.row, cur_req.chr};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- config writer ----------------
    logic [6:0] cfg_q [$];
    int         n_cfg_pushed = 0, n_cfg_done = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            classes_p = (cfg_data > dlml_pkg::MaxClasses) ? dlml_pkg::MaxClasses
                                                          : int'(cfg_data);
            n_cfg_done++;
            cfg_valid <= 1'b0;
        end else if (!cfg_valid && cfg_q.size() > 0) begin
            cfg_data <= cfg_q.pop_front();
            cfg_valid <= 1'b1;
        end
    end

    // ---------------- result sink and checker ----------------
    int hold_cnt = 0;
    bit hold_go = 1'b0;
    int errors = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (hold_go) begin
            hold_go = 1'b0;
            hold_cnt = HoldLen;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 12);
        end
    end

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        dlml_pkg::res_t want;
        bit             want_last;
        if (aresetn && m_tvalid && m_tready) begin
            if (tok_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual kind %0d tdata %h",
                         $realtime, m_tuser, m_tdata);
                errors++;
            end else begin
                want = tok_q.pop_front();
                want_last = tok_last_q.pop_front();
                check_field("result_kind", want.result_kind, m_tuser);
                check_field("token_type", want.token_type, m_tdata[7:0]);
                check_field("token_length", want.token_length, m_tdata[13:8]);
                check_field("first_line", want.first_line, m_tdata[45:14]);
                check_field("first_column", want.first_column, m_tdata[77:46]);
                check_field("last_line", want.last_line, m_tdata[109:78]);
                check_field("last_column", want.last_column, m_tdata[141:110]);
                check_field("last_of_run", want_last, m_tlast);
            end
        end
    end

    // ---------------- watchdog ----------------
    int stuck = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
            if (stuck >= IdleLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_req(logic [1:0] op, logic [7:0] chr, logic [7:0] row,
                            logic [6:0] col, logic signed [8:0] val);
        lex_req_t q;
        q.op = op;
        q.chr = chr;
        q.row = row;
        q.col = col;
        q.val = val;
        pend_q.push_back(q);
        n_pushed++;
    endtask

    function automatic logic [7:0] pick_byte();
        return Alphabet[$urandom_range(0, AlphaSize - 1)];
    endfunction

    task automatic push_byte(logic [7:0] b);
        push_req(dlml_pkg::OP_DATA, b, 8'($urandom), 7'($urandom), 9'($urandom));
    endtask

    task automatic push_eoi();
        push_req(dlml_pkg::OP_EOI, 8'($urandom), 8'($urandom), 7'($urandom), 9'($urandom));
    endtask

    // writes to rows and columns the scanner never reads
    task automatic push_junk();
        if ($urandom_range(0, 1) == 1)
            push_req(dlml_pkg::OP_TRANS, 8'($urandom), 8'($urandom),
                     7'($urandom_range(dlml_pkg::MaxClasses + 1, 127)), 9'($urandom));
        else
            push_req(dlml_pkg::OP_TRANS, 8'($urandom), 8'($urandom_range(Rows, 255)),
                     7'($urandom_range(0, dlml_pkg::MaxClasses)), 9'($urandom));
    endtask

    // state 0 always steps to an accepting state; deeper states may die or not
    // accept, which forces retraction
    function automatic logic signed [8:0] next_val(int s);
        int v;
        if (s == 0) v = int'($urandom_range(1, 2));
        else if (s == Rows - 1) v = -1;
        else if ($urandom_range(0, 3) == 0) v = -1;
        else v = int'($urandom_range(s + 1, Rows - 1));
        return 9'(v);
    endfunction

    function automatic logic signed [8:0] accept_val(int s);
        int v;
        if (s == 1 || s == 2) v = int'($urandom_range(0, 255));
        else if ($urandom_range(0, 1) == 1) v = -1;
        else v = int'($urandom_range(0, 255));
        return 9'(v);
    endfunction

    task automatic load_accept(int nc);
        for (int s = 0; s < Rows; s++)
            push_req(dlml_pkg::OP_TRANS, 8'($urandom), 8'(s), 7'(nc), accept_val(s));
    endtask

    task automatic load_dag(int nc);
        for (int i = 0; i < AlphaSize; i++)
            push_req(dlml_pkg::OP_CMAP, Alphabet[i], 8'($urandom), 7'($urandom),
                     9'($urandom_range(0, UsedClasses - 1)));
        for (int s = 0; s < Rows; s++)
            for (int c = 0; c < UsedClasses; c++)
                push_req(dlml_pkg::OP_TRANS, 8'($urandom), 8'(s), 7'(c), next_val(s));
        load_accept(nc);
        repeat (2) push_junk();
    endtask

    task automatic random_run(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 10) push_eoi();
            else if (r < 15) push_junk();
            else push_byte(pick_byte());
        end
        push_eoi();
    endtask

    task automatic drain();
        while (n_taken != n_pushed || tok_q.size() > 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
    endtask

    task automatic set_classes(logic [6:0] v);
        cfg_q.push_back(v);
        n_cfg_pushed++;
        while (n_cfg_done != n_cfg_pushed) @(posedge aclk);
    endtask

    initial begin
        fill_p = 0;
        classes_p = 1;
        line_p = 32'd1;
        col_p = '0;
        tok_line_p = '0;
        tok_col_p = '0;
        acc_line_p = '0;
        acc_col_p = '0;
        halt_p = 1'b0;
        restart_scan();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty end of input, extreme bytes, newlines, back-to-back ends
        set_classes(7'd4);
        load_dag(4);
        push_eoi();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(dlml_pkg::NEWLINE);
        push_byte(8'h41);
        push_byte(dlml_pkg::NEWLINE);
        push_byte(dlml_pkg::NEWLINE);
        push_eoi();
        push_eoi();
        repeat (6) push_byte(pick_byte());
        push_eoi();
        drain();

        // no idling on either side
        quiet = 1'b1;
        random_run(20);
        drain();
        quiet = 1'b0;

        // class count saturates; result side held while requests keep coming
        set_classes(7'd127);
        load_accept(dlml_pkg::MaxClasses);
        random_run(20);
        while (pend_q.size() > 20) @(posedge aclk);
        hold_go = 1'b1;
        drain();

        // self-looping accept state fills the lookahead, then overflow
        for (int c = 0; c < UsedClasses; c++) begin
            push_req(dlml_pkg::OP_TRANS, 8'($urandom), 8'd0, 7'(c), 9'sd1);
            push_req(dlml_pkg::OP_TRANS, 8'($urandom), 8'd1, 7'(c), 9'sd1);
        end
        push_req(dlml_pkg::OP_TRANS, 8'($urandom), 8'd1, 7'(dlml_pkg::MaxClasses), 9'sd77);
        repeat (dlml_pkg::MaxLexeme + 1) push_byte(pick_byte());
        push_eoi();
        push_byte(pick_byte());
        drain();

        // halted: writes still land, scanning stays silent
        set_classes(7'd0);
        push_req(dlml_pkg::OP_TRANS, 8'($urandom), 8'd0, 7'd0, -9'sd1);
        push_req(dlml_pkg::OP_CMAP, 8'h55, 8'($urandom), 7'($urandom), 9'sd3);
        push_byte(8'h55);
        push_eoi();
        drain();

        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/dlml_pkg.sv
rtl/dlml_ram.sv
rtl/dfa_longest_match_lexer.sv
bench/tb_top.sv
